// ===== design/tlpt_pkg.sv =====
// Package for the two-level page table engine: sizes, entry bits, codes,
// sequencer states and memory write port types. No dependencies.
`default_nettype none
package tlpt_pkg;

  localparam int DIR_INDEX_BITS   = 6;
  localparam int TABLE_INDEX_BITS = 6;
  localparam int PAGE_SHIFT       = 12;
  localparam int DIR_COUNT        = 1 << DIR_INDEX_BITS;
  localparam int TBL_COUNT        = 1 << TABLE_INDEX_BITS;
  localparam int SLOT_BITS        = DIR_INDEX_BITS + TABLE_INDEX_BITS;
  localparam int HUGE_BITS        = TABLE_INDEX_BITS + PAGE_SHIFT;
  localparam int START_W          = 6;
  localparam int WALK_W           = (DIR_INDEX_BITS > START_W ? DIR_INDEX_BITS : START_W) + 1;
  localparam int RUN_W            = (SLOT_BITS + 1 > 14) ? SLOT_BITS + 1 : 14;

  localparam logic [5:0]  START_RESET = 6'd48;
  localparam logic [31:0] FRAME_MASK  = 32'hFFFF_F000;
  localparam int          BIT_PRESENT = 0;
  localparam int          BIT_WRITE   = 1;
  localparam int          BIT_HUGE    = 7;

  typedef enum logic [2:0] {
    OP_TRANSLATE = 3'd0,
    OP_MAP       = 3'd1,
    OP_UNMAP     = 3'd2,
    OP_FIND_RUN  = 3'd3,
    OP_WRITE_DIR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_ALREADY    = 2'd2,
    ST_NO_RUN     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRD,
    S_DCHK,
    S_TRD,
    S_TCHK,
    S_CLR,
    S_TWR,
    S_FDIR,
    S_FDCHK,
    S_FTRD,
    S_FTCHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                      we;
    logic [DIR_INDEX_BITS-1:0] addr;
    logic [31:0]               data;
  } dir_wr_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] addr;
    logic [31:0]          data;
  } tbl_wr_t;

endpackage
`default_nettype wire

// ===== design/tlpt_dir_store.sv =====
// Page directory memory with one valid bit per entry (invalid reads as 0).
// Depends on tlpt_pkg.
`default_nettype none
module tlpt_dir_store (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire tlpt_pkg::dir_wr_t              wr_i,
  input  wire [tlpt_pkg::DIR_INDEX_BITS-1:0]  raddr_i,
  output logic [31:0]                         rdata_o
);
  import tlpt_pkg::*;

  logic [31:0]          mem_q [DIR_COUNT];
  logic [DIR_COUNT-1:0] vld_q;
  logic [31:0]          rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : 32'd0;
endmodule
`default_nettype wire

// ===== design/tlpt_tbl_store.sv =====
// Page table memory with one valid bit per table row; an invalid row reads 0.
// Depends on tlpt_pkg.
`default_nettype none
module tlpt_tbl_store (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire tlpt_pkg::tbl_wr_t         wr_i,
  input  wire [tlpt_pkg::SLOT_BITS-1:0]  raddr_i,
  output logic [31:0]                    rdata_o,
  output logic                           row_valid_o
);
  import tlpt_pkg::*;

  localparam int ENTRIES = DIR_COUNT * TBL_COUNT;

  logic [31:0]          mem_q [ENTRIES];
  logic [DIR_COUNT-1:0] row_vld_q;
  logic [31:0]          rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // a row is only written after a full zero sweep, so any write marks it valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      rvld_q <= row_vld_q[raddr_i[SLOT_BITS-1:TABLE_INDEX_BITS]];
      if (wr_i.we) begin
        row_vld_q[wr_i.addr[SLOT_BITS-1:TABLE_INDEX_BITS]] <= 1'b1;
      end
    end
  end

  assign rdata_o     = rvld_q ? rdata_q : 32'd0;
  assign row_valid_o = rvld_q;
endmodule
`default_nettype wire

// ===== design/two_level_page_table_engine.sv =====
// Two-level page table engine. Holds a 64-entry page directory and 64 page
// tables of 64 entries, all empty after reset (no clearing pass: per-entry
// and per-row valid bits stand in for it). One word at a time is taken on the
// input channel; the block stalls its input until the result word is loaded
// into the output register. A small sequencer drives one shared 32-bit adder
// and the two memory read ports, both with registered read data. Map first
// zeroes a table row when the directory entry is absent or the row is not yet
// valid. Find run walks the directory entries from the configured start and
// reads the entries of each present, non-huge table it meets, until a run of
// free pages is found or the directory ends.
// Depends on tlpt_pkg, tlpt_dir_store, tlpt_tbl_store.
`default_nettype none
module two_level_page_table_engine (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [5:0]   cfg_wdata_i,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire  [2:0]   op_i,
  input  wire  [23:0]  virtual_address_i,
  input  wire  [31:0]  physical_address_i,
  input  wire  [31:0]  table_frame_address_i,
  input  wire  [12:0]  page_count_i,
  input  wire  [31:0]  dir_entry_value_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output logic [1:0]   status_o,
  output logic [31:0]  result_address_o
);
  import tlpt_pkg::*;

  localparam int D = DIR_INDEX_BITS;
  localparam int T = TABLE_INDEX_BITS;

  state_e state_q, state_d;

  // latched request
  logic [2:0]  op_q;
  logic [31:0] va_q;
  logic [31:0] phys_q, tframe_q, dval_q;
  logic [12:0] cnt_q;
  logic [5:0]  start_q;

  // work registers
  logic [1:0]       status_q, status_d;
  logic [31:0]      res_q, res_d;
  logic [WALK_W-1:0] i_q, i_d;
  logic [T-1:0]     j_q, j_d;
  logic [RUN_W-1:0] n_q, n_d;
  logic [D-1:0]     si_q, si_d;
  logic [T-1:0]     sj_q, sj_d;
  logic             begin_q, begin_d;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_res_q;

  logic accept, out_free;
  logic [D-1:0] dir_idx;
  logic [T-1:0] tbl_idx;

  dir_wr_t            dir_wr;
  logic [D-1:0]       dir_raddr;
  logic [31:0]        de;
  tbl_wr_t            tbl_wr;
  logic [SLOT_BITS-1:0] tbl_raddr;
  logic [31:0]        te;
  logic               row_ok;

  // shared adder
  logic [31:0] add_a, add_b, sum;
  logic [RUN_W-1:0] need;
  logic run_hit;
  logic walk_end;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign dir_idx  = va_q[PAGE_SHIFT+T+D-1:PAGE_SHIFT+T];
  assign tbl_idx  = va_q[PAGE_SHIFT+T-1:PAGE_SHIFT];
  assign need     = (cnt_q == 13'd0) ? RUN_W'(1) : RUN_W'(cnt_q);
  assign run_hit  = sum[RUN_W-1:0] >= need;
  assign walk_end = i_q >= WALK_W'(DIR_COUNT);

  tlpt_dir_store u_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (dir_wr),
    .raddr_i (dir_raddr),
    .rdata_o (de)
  );

  tlpt_tbl_store u_tbl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (tbl_wr),
    .raddr_i     (tbl_raddr),
    .rdata_o     (te),
    .row_valid_o (row_ok)
  );

  // adder operand select
  always_comb begin
    add_a = 32'd0;
    add_b = 32'd0;
    unique case (state_q)
      S_DCHK: begin
        add_a = de & FRAME_MASK;
        add_b = 32'(va_q[HUGE_BITS-1:0]);
      end
      S_TCHK: begin
        add_a = te & FRAME_MASK;
        add_b = 32'(va_q[PAGE_SHIFT-1:0]);
      end
      S_FDCHK: begin
        add_a = 32'(n_q);
        add_b = 32'(TBL_COUNT);
      end
      S_FTCHK: begin
        add_a = 32'(n_q);
        add_b = 32'd1;
      end
      default: begin
        add_a = 32'd0;
        add_b = 32'd0;
      end
    endcase
  end
  assign sum = add_a + add_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_DRD;
      S_DRD:   state_d = S_DCHK;
      S_DCHK: begin
        priority case (op_q)
          OP_TRANSLATE, OP_UNMAP: begin
            state_d = (!de[BIT_PRESENT] || de[BIT_HUGE]) ? S_DONE : S_TRD;
          end
          OP_MAP: begin
            if (!de[BIT_PRESENT])   state_d = S_CLR;
            else if (de[BIT_HUGE])  state_d = S_DONE;
            else                    state_d = S_TRD;
          end
          OP_FIND_RUN: state_d = S_FDIR;
          default:     state_d = S_DONE;
        endcase
      end
      S_TRD:   state_d = S_TCHK;
      S_TCHK: begin
        if (op_q == OP_MAP && !te[BIT_PRESENT]) begin
          state_d = row_ok ? S_TWR : S_CLR;
        end else if (op_q == OP_UNMAP && te[BIT_PRESENT]) begin
          state_d = S_TWR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CLR:   if (&j_q) state_d = S_TWR;
      S_TWR:   state_d = S_DONE;
      S_FDIR:  state_d = walk_end ? S_DONE : S_FDCHK;
      S_FDCHK: begin
        if (!de[BIT_PRESENT]) state_d = run_hit ? S_DONE : S_FDIR;
        else if (de[BIT_HUGE]) state_d = S_FDIR;
        else                   state_d = S_FTRD;
      end
      S_FTRD:  state_d = S_FTCHK;
      S_FTCHK: begin
        if (!te[BIT_PRESENT] && run_hit) state_d = S_DONE;
        else if (&j_q)                    state_d = S_FDIR;
        else                              state_d = S_FTRD;
      end
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    status_d  = status_q;
    res_d     = res_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    si_d      = si_q;
    sj_d      = sj_q;
    begin_d   = begin_q;
    dir_raddr = dir_idx;
    tbl_raddr = {dir_idx, tbl_idx};
    dir_wr    = '0;
    tbl_wr    = '0;
    unique case (state_q)
      S_IDLE: begin
        status_d = ST_OK;
        res_d    = 32'd0;
        j_d      = '0;
        n_d      = '0;
        begin_d  = 1'b0;
      end
      S_DRD: begin
        dir_raddr = dir_idx;
        i_d       = WALK_W'(start_q);
      end
      S_DCHK: begin
        priority case (op_q)
          OP_TRANSLATE: begin
            if (!de[BIT_PRESENT]) status_d = ST_NOT_MAPPED;
            else if (de[BIT_HUGE]) res_d = sum;
          end
          OP_UNMAP: begin
            if (!de[BIT_PRESENT] || de[BIT_HUGE]) status_d = ST_NOT_MAPPED;
          end
          OP_MAP: begin
            if (!de[BIT_PRESENT]) begin
              dir_wr.we   = 1'b1;
              dir_wr.addr = dir_idx;
              dir_wr.data = (tframe_q & FRAME_MASK) | (32'd1 << BIT_PRESENT)
                            | (32'd1 << BIT_WRITE);
            end else if (de[BIT_HUGE]) begin
              status_d = ST_ALREADY;
            end
          end
          OP_WRITE_DIR: begin
            dir_wr.we   = 1'b1;
            dir_wr.addr = dir_idx;
            dir_wr.data = dval_q;
          end
          default: ;
        endcase
      end
      S_TRD: tbl_raddr = {dir_idx, tbl_idx};
      S_TCHK: begin
        if (op_q == OP_TRANSLATE) begin
          if (te[BIT_PRESENT]) res_d = sum;
          else status_d = ST_NOT_MAPPED;
        end else if (op_q == OP_MAP) begin
          if (te[BIT_PRESENT]) status_d = ST_ALREADY;
        end else if (!te[BIT_PRESENT]) begin
          status_d = ST_NOT_MAPPED;
        end
        j_d = '0;
      end
      S_CLR: begin
        tbl_wr.we   = 1'b1;
        tbl_wr.addr = {dir_idx, j_q};
        tbl_wr.data = 32'd0;
        j_d         = j_q + T'(1);
      end
      S_TWR: begin
        tbl_wr.we   = 1'b1;
        tbl_wr.addr = {dir_idx, tbl_idx};
        tbl_wr.data = (op_q == OP_MAP) ? ((phys_q & FRAME_MASK) | (32'd1 << BIT_PRESENT)
                      | (32'd1 << BIT_WRITE)) : 32'd0;
      end
      S_FDIR: begin
        dir_raddr = i_q[D-1:0];
        if (walk_end) status_d = ST_NO_RUN;
      end
      S_FDCHK: begin
        j_d = '0;
        if (!de[BIT_PRESENT]) begin
          // absent table counts as a full row of free pages
          if (!begin_q) begin
            si_d    = i_q[D-1:0];
            sj_d    = '0;
            begin_d = 1'b1;
          end
          n_d = sum[RUN_W-1:0];
          if (run_hit) begin
            res_d = 32'({(begin_q ? si_q : i_q[D-1:0]), (begin_q ? sj_q : T'(0)),
                         PAGE_SHIFT'(0)});
          end
          i_d = i_q + WALK_W'(1);
        end else if (de[BIT_HUGE]) begin
          begin_d = 1'b0;
          n_d     = '0;
          i_d     = i_q + WALK_W'(1);
        end
      end
      S_FTRD: tbl_raddr = {i_q[D-1:0], j_q};
      S_FTCHK: begin
        if (te[BIT_PRESENT]) begin
          begin_d = 1'b0;
          n_d     = '0;
        end else begin
          if (!begin_q) begin
            si_d    = i_q[D-1:0];
            sj_d    = j_q;
            begin_d = 1'b1;
          end
          n_d = sum[RUN_W-1:0];
          if (run_hit) begin
            res_d = 32'({(begin_q ? si_q : i_q[D-1:0]), (begin_q ? sj_q : j_q),
                         PAGE_SHIFT'(0)});
          end
        end
        j_d = j_q + T'(1);
        if (&j_q) i_d = i_q + WALK_W'(1);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= START_RESET;
      out_valid_q <= 1'b0;
      begin_q     <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q <= state_d;
      begin_q <= begin_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_q    <= res_d;
    si_q     <= si_d;
    sj_q     <= sj_d;
    if (accept) begin
      op_q     <= op_i;
      va_q     <= {8'd0, virtual_address_i};
      phys_q   <= physical_address_i;
      tframe_q <= table_frame_address_i;
      cnt_q    <= page_count_i;
      dval_q   <= dir_entry_value_i;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= status_q;
      out_res_q    <= res_q;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_address_o = out_res_q;

  // an error status never carries an address
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_address_o == 32'd0)
    else $error("error status with nonzero address");

  // a taken word starts a walk, so input stalls next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only arrives from the done state
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result without finished walk");

endmodule
`default_nettype wire

// ===== tb/two_level_page_table_engine_tb.sv =====
// Self-checking bench for two_level_page_table_engine: directed and random
// translate/map/unmap/find-run/write-dir words against an in-bench page model.
// Depends on tlpt_pkg and the engine RTL.
`timescale 1ns / 1ps
module two_level_page_table_engine_tb;
  import tlpt_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [23:0] va;
    logic [31:0] pa;
    logic [31:0] tf;
    logic [12:0] cnt;
    logic [31:0] dval;
  } req_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] addr;
  } rsp_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [5:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [2:0] op_i = '0;
  logic [23:0] virtual_address_i = '0;
  logic [31:0] physical_address_i = '0;
  logic [31:0] table_frame_address_i = '0;
  logic [12:0] page_count_i = '0;
  logic [31:0] dir_entry_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [1:0] status_o;
  logic [31:0] result_address_o;

  two_level_page_table_engine uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o, .op_i,
    .virtual_address_i, .physical_address_i, .table_frame_address_i,
    .page_count_i, .dir_entry_value_i, .out_valid_o, .out_stall_i, .status_o,
    .result_address_o
  );

  // Shadow copy of the engine state
  logic [31:0] pdir [DIR_COUNT];
  logic [31:0] ptab [DIR_COUNT*TBL_COUNT];
  logic [5:0]  run_start = START_RESET;

  req_t pending_words[$];
  rsp_t expected_rsp[$];
  int   send_idle_pct = 0, stall_pct = 0;
  int   mismatches = 0, checked = 0;
  int   op_seen [8];

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #500ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // First-fit search for a run of free pages from the configured start.
  function automatic rsp_t find_free_run(logic [12:0] cnt);
    rsp_t r;
    int need, n, si, sj;
    bit open;
    need = (cnt == 0) ? 1 : cnt;
    n = 0; open = 0; si = 0; sj = 0;
    r.st = ST_NO_RUN; r.addr = '0;
    for (int i = run_start; i < DIR_COUNT; i++) begin
      if (pdir[i][BIT_PRESENT]) begin
        if (pdir[i][BIT_HUGE]) begin
          open = 0; n = 0;
          continue;
        end
        for (int j = 0; j < TBL_COUNT; j++) begin
          if (ptab[i*TBL_COUNT+j][BIT_PRESENT]) begin
            open = 0; n = 0;
          end else begin
            if (!open) begin si = i; sj = j; open = 1; end
            n++;
            if (n >= need) break;
          end
        end
      end else begin
        if (!open) begin si = i; sj = 0; open = 1; end
        n += TBL_COUNT;
      end
      if (n >= need) begin
        r.st = ST_OK;
        r.addr = 32'((si << HUGE_BITS) + (sj << PAGE_SHIFT));
        return r;
      end
    end
    return r;
  endfunction

  // Apply one request to the shadow state and return its response.
  function automatic rsp_t page_engine_step(req_t q);
    rsp_t r;
    int d, t, s;
    logic [31:0] de;
    d = q.va[HUGE_BITS +: DIR_INDEX_BITS];
    t = q.va[PAGE_SHIFT +: TABLE_INDEX_BITS];
    s = d*TBL_COUNT + t;
    de = pdir[d];
    r.st = ST_OK; r.addr = '0;
    case (q.op)
      OP_TRANSLATE: begin
        if (!de[BIT_PRESENT]) r.st = ST_NOT_MAPPED;
        else if (de[BIT_HUGE])
          r.addr = (de & FRAME_MASK) + {14'd0, q.va[HUGE_BITS-1:0]};
        else if (ptab[s][BIT_PRESENT])
          r.addr = (ptab[s] & FRAME_MASK) + {20'd0, q.va[11:0]};
        else r.st = ST_NOT_MAPPED;
      end
      OP_MAP: begin
        if (de[BIT_PRESENT] && de[BIT_HUGE]) r.st = ST_ALREADY;
        else begin
          if (!de[BIT_PRESENT]) begin
            pdir[d] = (q.tf & FRAME_MASK) | 32'h3;
            for (int j = 0; j < TBL_COUNT; j++) ptab[d*TBL_COUNT+j] = '0;
          end
          if (ptab[s][BIT_PRESENT]) r.st = ST_ALREADY;
          else ptab[s] = (q.pa & FRAME_MASK) | 32'h3;
        end
      end
      OP_UNMAP: begin
        if (!de[BIT_PRESENT] || de[BIT_HUGE] || !ptab[s][BIT_PRESENT])
          r.st = ST_NOT_MAPPED;
        else ptab[s] = '0;
      end
      OP_FIND_RUN: r = find_free_run(q.cnt);
      OP_WRITE_DIR: pdir[d] = q.dval;
      default: ;
    endcase
    return r;
  endfunction

  // Driver: present the head of the pending queue, hold it while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsp.push_back(page_engine_step(pending_words.pop_front()));
      end
      if ((!in_valid_i || !in_stall_o)) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op_i <= pending_words[0].op;
          virtual_address_i <= pending_words[0].va;
          physical_address_i <= pending_words[0].pa;
          table_frame_address_i <= pending_words[0].tf;
          page_count_i <= pending_words[0].cnt;
          dir_entry_value_i <= pending_words[0].dval;
          in_valid_i <= 1;
        end else begin
          in_valid_i <= 0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d addr %h", status_o, result_address_o);
      end else begin
        rsp_t e;
        e = expected_rsp.pop_front();
        checked++;
        if (status_o !== e.st || result_address_o !== e.addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, addr exp %h got %h",
                     e.st, status_o, e.addr, result_address_o);
        end
      end
    end
  end

  function automatic req_t rand_req(int op);
    req_t q;
    logic [5:0] dsel, tsel;
    dsel = 6'($urandom_range(47, 40));
    tsel = 6'($urandom_range(63));
    q.op = op[2:0];
    q.va = ($urandom_range(3) == 0) ? 24'($urandom) :
           {dsel, tsel, 12'($urandom_range(4095))};
    q.pa = $urandom;
    q.tf = $urandom;
    q.cnt = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(130, 1));
    q.dval = $urandom;
    if (op == OP_WRITE_DIR && $urandom_range(1)) q.dval[BIT_HUGE] = 0;
    return q;
  endfunction

  task automatic queue_word(req_t q);
    pending_words.push_back(q);
    op_seen[q.op]++;
  endtask

  // Drain all traffic, then a short idle tail before the next phase.
  task automatic drain_engine();
    while (pending_words.size() != 0 || expected_rsp.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_run_start(logic [5:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    run_start = v;
  endtask

  initial begin
    req_t q;
    int pcts [4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{13, 13}};
    int starts [4] = '{0, 63, 40, 48};
    for (int i = 0; i < DIR_COUNT; i++) pdir[i] = '0;
    for (int i = 0; i < DIR_COUNT*TBL_COUNT; i++) ptab[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty-table translate, find run at reset start, map with a
    // fresh table, remap, huge entries, bad unmaps, unused op codes.
    q = rand_req(OP_TRANSLATE); q.va = 24'h000000; queue_word(q);
    q = rand_req(OP_TRANSLATE); q.va = 24'hFFFFFF; queue_word(q);
    q = rand_req(OP_FIND_RUN); q.cnt = 13'd0; queue_word(q);
    q = rand_req(OP_FIND_RUN); q.cnt = 13'd4096; queue_word(q);
    q = rand_req(OP_FIND_RUN); q.cnt = 13'h1FFF; queue_word(q);
    q = rand_req(OP_MAP); q.va = 24'hC00000; q.pa = 32'hFFFFFFFF; queue_word(q);
    q = rand_req(OP_MAP); q.va = 24'hC00000; queue_word(q);
    q = rand_req(OP_MAP); q.va = 24'hC3F000; q.pa = 32'h0; queue_word(q);
    q = rand_req(OP_TRANSLATE); q.va = 24'hC00FFF; queue_word(q);
    q = rand_req(OP_TRANSLATE); q.va = 24'hC01000; queue_word(q);
    q = rand_req(OP_FIND_RUN); q.cnt = 13'd1; queue_word(q);
    q = rand_req(OP_UNMAP); q.va = 24'hC00000; queue_word(q);
    q = rand_req(OP_UNMAP); q.va = 24'hC00000; queue_word(q);
    q = rand_req(OP_UNMAP); q.va = 24'h000000; queue_word(q);
    q = rand_req(OP_WRITE_DIR); q.va = 24'hFC0000; q.dval = 32'hFFFFF081; queue_word(q);
    q = rand_req(OP_TRANSLATE); q.va = 24'hFFFFFF; queue_word(q);
    q = rand_req(OP_MAP); q.va = 24'hFC0000; queue_word(q);
    q = rand_req(OP_UNMAP); q.va = 24'hFC0000; queue_word(q);
    q = rand_req(OP_FIND_RUN); q.cnt = 13'd1000; queue_word(q);
    q = rand_req(OP_WRITE_DIR); q.va = 24'hF80000; q.dval = 32'h00000000; queue_word(q);
    q = rand_req(5); queue_word(q);
    q = rand_req(7); queue_word(q);
    drain_engine();

    // Random phases, each under its own idle/stall mix and search start.
    for (int ph = 0; ph < 4; ph++) begin
      set_run_start(starts[ph][5:0]);
      send_idle_pct = pcts[ph][0];
      stall_pct = pcts[ph][1];
      for (int n = 0; n < 210; n++) begin
        int r, op;
        r = $urandom_range(99);
        op = r < 30 ? OP_MAP : r < 55 ? OP_TRANSLATE : r < 72 ? OP_UNMAP :
             r < 85 ? OP_FIND_RUN : r < 97 ? OP_WRITE_DIR : $urandom_range(7, 5);
        queue_word(rand_req(op));
      end
      drain_engine();
    end

    $display("checked %0d result words: %0d translate, %0d map, %0d unmap, %0d find, %0d dir",
             checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
